// ===== sv/mfp_pkg.sv =====
// mfp_pkg: shared types, constants and functions of the MAVLink frame parser.
// Holds the parse phase encoding, the result record, the CRC-16/MCRF4XX fold
// and the per-message seed lookup. No dependencies.
package mfp_pkg;

  localparam logic [7:0]  STX_ONE  = 8'hFE;
  localparam logic [7:0]  STX_TWO  = 8'hFD;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef enum logic [12:0] {
    PH_IDLE     = 13'b0_0000_0000_0001,
    PH_LEN      = 13'b0_0000_0000_0010,
    PH_INCOMPAT = 13'b0_0000_0000_0100,
    PH_COMPAT   = 13'b0_0000_0000_1000,
    PH_SEQ      = 13'b0_0000_0001_0000,
    PH_SYS      = 13'b0_0000_0010_0000,
    PH_COMP     = 13'b0_0000_0100_0000,
    PH_MID1     = 13'b0_0000_1000_0000,
    PH_MID2     = 13'b0_0001_0000_0000,
    PH_MID3     = 13'b0_0010_0000_0000,
    PH_PAYLOAD  = 13'b0_0100_0000_0000,
    PH_CRC1     = 13'b0_1000_0000_0000,
    PH_CRC2     = 13'b1_0000_0000_0000
  } phase_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_index;
    logic [7:0]  payload_value;
    logic        crc_good;
    logic        is_version_two;
    logic [7:0]  system_id;
    logic [7:0]  component_id;
    logic [23:0] message_id;
    logic [7:0]  payload_length;
  } res_t;

  // Fold one byte into a CRC-16/MCRF4XX (reflected 0x1021) accumulator.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

  // Per-message CRC seed byte; unknown ids give zero.
  function automatic logic [7:0] msg_seed(input logic [23:0] id);
    logic [7:0] v;
    unique case (id)
      24'd0:   v = 8'd50;
      24'd1:   v = 8'd124;
      24'd11:  v = 8'd89;
      24'd24:  v = 8'd24;
      24'd30:  v = 8'd39;
      24'd33:  v = 8'd104;
      24'd69:  v = 8'd243;
      24'd74:  v = 8'd20;
      24'd76:  v = 8'd152;
      24'd77:  v = 8'd143;
      24'd86:  v = 8'd5;
      24'd253: v = 8'd83;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/mfp_fsm.sv =====
// mfp_fsm: frame walker of the MAVLink parser; phase, CRC and header state.
// Produces at most one result record per accepted byte, combinationally.
// Depends on mfp_pkg.
module mfp_fsm (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_acc,
  input  logic [7:0]    rx_byte,
  output logic          res_valid,
  output mfp_pkg::res_t res
);

  mfp_pkg::phase_t phase_r, phase_nxt;
  logic        v2_r, v2_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  sys_r, sys_nxt;
  logic [7:0]  comp_r, comp_nxt;
  logic [23:0] mid_r, mid_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [7:0]  cnt_inc;
  mfp_pkg::phase_t body_phase;

  assign cnt_inc    = cnt_r + 8'd1;
  // after the message id: skip straight to the CRC on an empty payload
  assign body_phase = (len_r != 8'd0) ? mfp_pkg::PH_PAYLOAD : mfp_pkg::PH_CRC1;

  always_comb begin
    phase_nxt  = phase_r;
    v2_nxt     = v2_r;
    crc_nxt    = crc_r;
    len_nxt    = len_r;
    sys_nxt    = sys_r;
    comp_nxt   = comp_r;
    mid_nxt    = mid_r;
    cnt_nxt    = cnt_r;
    crc_lo_nxt = crc_lo_r;
    res_valid  = 1'b0;
    res.kind           = mfp_pkg::KIND_PAYLOAD;
    res.payload_index  = 8'd0;
    res.payload_value  = 8'd0;
    res.crc_good       = 1'b0;
    res.is_version_two = v2_r;
    res.system_id      = sys_r;
    res.component_id   = comp_r;
    res.message_id     = mid_r;
    res.payload_length = len_r;
    if (byte_acc) begin
      unique case (phase_r)
        mfp_pkg::PH_LEN: begin
          len_nxt   = rx_byte;
          crc_nxt   = mfp_pkg::crc_fold(crc_r, rx_byte);
          phase_nxt = v2_r ? mfp_pkg::PH_INCOMPAT : mfp_pkg::PH_SEQ;
        end
        mfp_pkg::PH_INCOMPAT: begin
          crc_nxt   = mfp_pkg::crc_fold(crc_r, rx_byte);
          phase_nxt = mfp_pkg::PH_COMPAT;
        end
        mfp_pkg::PH_COMPAT: begin
          crc_nxt   = mfp_pkg::crc_fold(crc_r, rx_byte);
          phase_nxt = mfp_pkg::PH_SEQ;
        end
        mfp_pkg::PH_SEQ: begin
          crc_nxt   = mfp_pkg::crc_fold(crc_r, rx_byte);
          phase_nxt = mfp_pkg::PH_SYS;
        end
        mfp_pkg::PH_SYS: begin
          sys_nxt   = rx_byte;
          crc_nxt   = mfp_pkg::crc_fold(crc_r, rx_byte);
          phase_nxt = mfp_pkg::PH_COMP;
        end
        mfp_pkg::PH_COMP: begin
          comp_nxt  = rx_byte;
          crc_nxt   = mfp_pkg::crc_fold(crc_r, rx_byte);
          phase_nxt = mfp_pkg::PH_MID1;
        end
        mfp_pkg::PH_MID1: begin
          mid_nxt = {16'h0000, rx_byte};
          crc_nxt = mfp_pkg::crc_fold(crc_r, rx_byte);
          if (v2_r) begin
            phase_nxt = mfp_pkg::PH_MID2;
          end else begin
            cnt_nxt   = 8'd0;
            phase_nxt = body_phase;
          end
        end
        mfp_pkg::PH_MID2: begin
          mid_nxt   = {mid_r[23:16], rx_byte, mid_r[7:0]};
          crc_nxt   = mfp_pkg::crc_fold(crc_r, rx_byte);
          phase_nxt = mfp_pkg::PH_MID3;
        end
        mfp_pkg::PH_MID3: begin
          mid_nxt   = {rx_byte, mid_r[15:0]};
          crc_nxt   = mfp_pkg::crc_fold(crc_r, rx_byte);
          cnt_nxt   = 8'd0;
          phase_nxt = body_phase;
        end
        mfp_pkg::PH_PAYLOAD: begin
          res_valid         = 1'b1;
          res.payload_index = cnt_r;
          res.payload_value = rx_byte;
          crc_nxt           = mfp_pkg::crc_fold(crc_r, rx_byte);
          cnt_nxt           = cnt_inc;
          if (cnt_inc >= len_r) begin
            phase_nxt = mfp_pkg::PH_CRC1;
          end
        end
        mfp_pkg::PH_CRC1: begin
          crc_nxt    = mfp_pkg::crc_fold(crc_r, mfp_pkg::msg_seed(mid_r));
          crc_lo_nxt = rx_byte;
          phase_nxt  = mfp_pkg::PH_CRC2;
        end
        mfp_pkg::PH_CRC2: begin
          res_valid    = 1'b1;
          res.kind     = mfp_pkg::KIND_END;
          res.crc_good = ({rx_byte, crc_lo_r} == crc_r);
          phase_nxt    = mfp_pkg::PH_IDLE;
        end
        default: begin
          // hunt for a start byte; unknown codes behave the same
          if (rx_byte == mfp_pkg::STX_TWO) begin
            v2_nxt    = 1'b1;
            crc_nxt   = mfp_pkg::CRC_INIT;
            phase_nxt = mfp_pkg::PH_LEN;
          end else if (rx_byte == mfp_pkg::STX_ONE) begin
            v2_nxt    = 1'b0;
            crc_nxt   = mfp_pkg::CRC_INIT;
            phase_nxt = mfp_pkg::PH_LEN;
          end else begin
            phase_nxt = mfp_pkg::PH_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= mfp_pkg::PH_IDLE;
      v2_r     <= 1'b0;
      crc_r    <= mfp_pkg::CRC_INIT;
      len_r    <= 8'd0;
      sys_r    <= 8'd0;
      comp_r   <= 8'd0;
      mid_r    <= 24'd0;
      cnt_r    <= 8'd0;
      crc_lo_r <= 8'd0;
    end else begin
      phase_r  <= phase_nxt;
      v2_r     <= v2_nxt;
      crc_r    <= crc_nxt;
      len_r    <= len_nxt;
      sys_r    <= sys_nxt;
      comp_r   <= comp_nxt;
      mid_r    <= mid_nxt;
      cnt_r    <= cnt_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  a_end_only_from_crc2: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == mfp_pkg::KIND_END) |-> phase_r == mfp_pkg::PH_CRC2)
    else $error("end-of-frame result outside the second CRC byte");

  a_crc2_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_acc && phase_r == mfp_pkg::PH_CRC2) |=> phase_r == mfp_pkg::PH_IDLE)
    else $error("parser did not return to idle after the frame");

  a_payload_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == mfp_pkg::PH_PAYLOAD |-> cnt_r < len_r)
    else $error("payload index reached the frame length");

  a_start_seeds_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_acc && phase_r == mfp_pkg::PH_IDLE
     && (rx_byte == mfp_pkg::STX_ONE || rx_byte == mfp_pkg::STX_TWO))
    |=> (crc_r == mfp_pkg::CRC_INIT && phase_r == mfp_pkg::PH_LEN))
    else $error("start byte did not seed the CRC");

endmodule

// ===== sv/mavlink_frame_parser.sv =====
// mavlink_frame_parser: MAVLink v1/v2 frame parser, one received byte per
// transaction, streaming payload bytes and one end-of-frame CRC verdict.
// Depends on mfp_pkg and mfp_fsm.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   in_     | input     | in_valid / in_stall  | in_rx_byte
//   out_    | output    | out_valid / out_stall| kind, index, value, crc_good,
//           |           |                      | version, ids, message id, length
//
// One byte per cycle while in_stall is low: the phase step and CRC fold finish
// in the byte's cycle; its result is in the output or skid register the next.
// Reset (rst_n low, synchronous) returns to hunting for a start byte with the
// CRC at 0xFFFF and empties both result registers.
// A stalled output fills one skid register; in_stall is high while that skid
// register is occupied, so each result parked under a consumer stall holds off
// the input until it drains into the output.
module mavlink_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_payload_index,
  output logic [7:0]  out_payload_value,
  output logic        out_crc_good,
  output logic        out_is_version_two,
  output logic [7:0]  out_system_id,
  output logic [7:0]  out_component_id,
  output logic [23:0] out_message_id,
  output logic [7:0]  out_payload_length
);

  logic          in_acc;
  logic          res_valid;
  mfp_pkg::res_t res;

  // output register plus one skid stage
  logic          out_v_r, out_v_nxt;
  mfp_pkg::res_t out_res_r, out_res_nxt;
  logic          skid_v_r, skid_v_nxt;
  mfp_pkg::res_t skid_res_r, skid_res_nxt;
  logic          out_free;

  // hold off the sender only while the skid stage holds a result
  assign in_stall = skid_v_r;
  assign in_acc   = in_valid && !in_stall;

  mfp_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_acc  (in_acc),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register may load when empty or being drained this cycle
  assign out_free = !out_v_r || !out_stall;

  always_comb begin
    out_v_nxt    = out_v_r;
    out_res_nxt  = out_res_r;
    skid_v_nxt   = skid_v_r;
    skid_res_nxt = skid_res_r;
    if (out_free) begin
      if (skid_v_r) begin
        // drain the skid first; no new byte is taken while it is full
        out_v_nxt   = 1'b1;
        out_res_nxt = skid_res_r;
        skid_v_nxt  = 1'b0;
      end else begin
        out_v_nxt   = res_valid;
        out_res_nxt = res;
      end
    end else if (res_valid) begin
      // output stalled: park the new result
      skid_v_nxt   = 1'b1;
      skid_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid          = out_v_r;
  assign out_result_kind    = out_res_r.kind;
  assign out_payload_index  = out_res_r.payload_index;
  assign out_payload_value  = out_res_r.payload_value;
  assign out_crc_good       = out_res_r.crc_good;
  assign out_is_version_two = out_res_r.is_version_two;
  assign out_system_id      = out_res_r.system_id;
  assign out_component_id   = out_res_r.component_id;
  assign out_message_id     = out_res_r.message_id;
  assign out_payload_length = out_res_r.payload_length;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds a result while output is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_stall) |=> !skid_v_r)
    else $error("skid register did not drain into the output");

  a_stalled_result_parked: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && out_v_r && out_stall && !skid_v_r) |=> skid_v_r)
    else $error("result produced under output stall was lost");

endmodule

// ===== tb/mavlink_frame_parser_tb.sv =====
`timescale 1ns / 1ps
// mavlink_frame_parser_tb: self-checking testbench for the MAVLink v1/v2 frame parser.
// Streams directed and random byte traffic, predicts every result in-bench and
// checks it field by field. Depends on mfp_pkg and mavlink_frame_parser.
module mavlink_frame_parser_tb;

  // Bound the run well above the slowest legal pass.
  localparam int LIMIT_CYCLES = 1_000_000;
  // Let the pipeline settle after the last expected result.
  localparam int DRAIN_CYCLES = 20;
  localparam int SIG_BYTES    = 13;

  // Message ids that carry a per-message CRC seed, and the seed of each.
  localparam logic [23:0] EXTRA_IDS [12] = '{24'd0, 24'd1, 24'd11, 24'd24, 24'd30, 24'd33,
                                             24'd69, 24'd74, 24'd76, 24'd77, 24'd86, 24'd253};
  localparam logic [7:0] EXTRA_SEEDS [12] = '{8'd50, 8'd124, 8'd89, 8'd24, 8'd39, 8'd104,
                                              8'd243, 8'd20, 8'd152, 8'd143, 8'd5, 8'd83};

  // Where the shadow parser stands within a frame.
  typedef enum logic [3:0] {
    HUNT, GET_LEN, GET_INCOMPAT, GET_COMPAT, GET_SEQ, GET_SYS, GET_COMP,
    GET_MID1, GET_MID2, GET_MID3, GET_PAYLOAD, GET_CRC_LO, GET_CRC_HI
  } frame_phase_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_result_kind;
  logic [7:0]  out_payload_index;
  logic [7:0]  out_payload_value;
  logic        out_crc_good;
  logic        out_is_version_two;
  logic [7:0]  out_system_id;
  logic [7:0]  out_component_id;
  logic [23:0] out_message_id;
  logic [7:0]  out_payload_length;

  mavlink_frame_parser DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_payload_index  (out_payload_index),
    .out_payload_value  (out_payload_value),
    .out_crc_good       (out_crc_good),
    .out_is_version_two (out_is_version_two),
    .out_system_id      (out_system_id),
    .out_component_id   (out_component_id),
    .out_message_id     (out_message_id),
    .out_payload_length (out_payload_length)
  );

  // Shadow copy of the parser state.
  frame_phase_t phase;
  logic         v2_frame;
  logic [15:0]  frame_crc;
  logic [7:0]   frame_len;
  logic [7:0]   frame_sys;
  logic [7:0]   frame_comp;
  logic [23:0]  frame_msg_id;
  logic [7:0]   payload_pos;
  logic [7:0]   crc_lo_rx;

  // Results still owed by the parser, oldest first.
  mfp_pkg::res_t pending_results[$];

  int  error_count;
  int  cycle_count;
  int  bytes_sent;
  bit  gaps_on;
  bit  stalls_on;
  int  stall_left;
  int  stall_roll;

  // Clock: 20 ns period.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // CRC-16/MCRF4XX, bit-serial form: reflected polynomial 0x8408.
  function automatic logic [15:0] crc_mcrf(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    end
    return c;
  endfunction

  // Look up the per-message seed; ids outside the table seed with zero.
  function automatic logic [7:0] extra_seed(input logic [23:0] id);
    logic [7:0] seed;
    seed = 8'h00;
    for (int i = 0; i < 12; i++) begin
      if (EXTRA_IDS[i] == id) begin
        seed = EXTRA_SEEDS[i];
      end
    end
    return seed;
  endfunction

  // Queue one expected result stamped with the current frame header.
  task automatic owe_result(input mfp_pkg::kind_t kind, input logic [7:0] idx,
                            input logic [7:0] val, input logic good);
    mfp_pkg::res_t r;
    r.kind           = kind;
    r.payload_index  = idx;
    r.payload_value  = val;
    r.crc_good       = good;
    r.is_version_two = v2_frame;
    r.system_id      = frame_sys;
    r.component_id   = frame_comp;
    r.message_id     = frame_msg_id;
    r.payload_length = frame_len;
    pending_results.push_back(r);
  endtask

  // Advance the shadow parser by one accepted byte.
  task automatic parse_byte(input logic [7:0] b);
    case (phase)
      GET_LEN: begin
        frame_len = b;
        frame_crc = crc_mcrf(frame_crc, b);
        phase     = v2_frame ? GET_INCOMPAT : GET_SEQ;
      end
      GET_INCOMPAT: begin
        frame_crc = crc_mcrf(frame_crc, b);
        phase     = GET_COMPAT;
      end
      GET_COMPAT: begin
        frame_crc = crc_mcrf(frame_crc, b);
        phase     = GET_SEQ;
      end
      GET_SEQ: begin
        frame_crc = crc_mcrf(frame_crc, b);
        phase     = GET_SYS;
      end
      GET_SYS: begin
        frame_sys = b;
        frame_crc = crc_mcrf(frame_crc, b);
        phase     = GET_COMP;
      end
      GET_COMP: begin
        frame_comp = b;
        frame_crc  = crc_mcrf(frame_crc, b);
        phase      = GET_MID1;
      end
      GET_MID1, GET_MID3: begin
        if (phase == GET_MID1) begin
          frame_msg_id = {16'h0000, b};
        end else begin
          frame_msg_id[23:16] = b;
        end
        frame_crc = crc_mcrf(frame_crc, b);
        if (phase == GET_MID1 && v2_frame) begin
          phase = GET_MID2;
        end else begin
          // An empty payload goes straight to the CRC bytes.
          payload_pos = 8'h00;
          phase       = (frame_len != 8'h00) ? GET_PAYLOAD : GET_CRC_LO;
        end
      end
      GET_MID2: begin
        frame_msg_id[15:8] = b;
        frame_crc = crc_mcrf(frame_crc, b);
        phase     = GET_MID3;
      end
      GET_PAYLOAD: begin
        owe_result(mfp_pkg::KIND_PAYLOAD, payload_pos, b, 1'b0);
        frame_crc   = crc_mcrf(frame_crc, b);
        payload_pos = payload_pos + 8'd1;
        if (payload_pos >= frame_len) begin
          phase = GET_CRC_LO;
        end
      end
      GET_CRC_LO: begin
        frame_crc = crc_mcrf(frame_crc, extra_seed(frame_msg_id));
        crc_lo_rx = b;
        phase     = GET_CRC_HI;
      end
      GET_CRC_HI: begin
        owe_result(mfp_pkg::KIND_END, 8'h00, 8'h00, {b, crc_lo_rx} == frame_crc);
        phase = HUNT;
      end
      default: begin
        // Outside a frame only a start byte matters; everything else is dropped.
        if (b == mfp_pkg::STX_TWO || b == mfp_pkg::STX_ONE) begin
          v2_frame  = (b == mfp_pkg::STX_TWO);
          frame_crc = mfp_pkg::CRC_INIT;
          phase     = GET_LEN;
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Checking: compare each result transaction, then fold in any accepted byte.
  // Doing both in one process keeps a new expectation from being popped early.
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    mfp_pkg::res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, got kind %0d",
                   $time, out_result_kind);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("result_kind", 24'(want.kind), 24'(out_result_kind));
          check_field("payload_index", 24'(want.payload_index), 24'(out_payload_index));
          check_field("payload_value", 24'(want.payload_value), 24'(out_payload_value));
          check_field("crc_good", 24'(want.crc_good), 24'(out_crc_good));
          check_field("is_version_two", 24'(want.is_version_two),
                      24'(out_is_version_two));
          check_field("system_id", 24'(want.system_id), 24'(out_system_id));
          check_field("component_id", 24'(want.component_id), 24'(out_component_id));
          check_field("message_id", want.message_id, out_message_id);
          check_field("payload_length", 24'(want.payload_length),
                      24'(out_payload_length));
        end
      end
      if (in_valid && !in_stall) begin
        parse_byte(in_rx_byte);
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Consumer: stall the result channel in bursts, mostly short, a few long.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!stalls_on) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 75) begin
        out_stall <= 1'b0;
      end else begin
        out_stall  <= 1'b1;
        stall_left = (stall_roll < 96) ? $urandom_range(0, 2) : $urandom_range(7, 39);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Producer
  // ---------------------------------------------------------------------------

  // Idle length ahead of the next byte: usually none, sometimes short, rarely long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 70) begin
      return 0;
    end
    return (roll < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Send one byte transaction: optional idle, then hold it until accepted.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Mostly ids with a known seed, otherwise unknown ones of any width.
  function automatic logic [23:0] pick_msg_id();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) begin
      return EXTRA_IDS[$urandom_range(0, 11)];
    end
    return (roll < 8) ? 24'($urandom_range(0, 255)) : 24'($urandom);
  endfunction

  // Build one frame and send it, or only its first keep bytes when keep > 0.
  // stx_pct is the chance that a payload byte is a start byte.
  task automatic send_frame(input bit v2, input int len, input logic [7:0] sys,
                            input logic [7:0] comp, input logic [23:0] msg_id,
                            input bit bad_crc, input bit signed_frame,
                            input int stx_pct, input int keep);
    logic [7:0]  body[$];
    logic [7:0]  wire_bytes[$];
    logic [15:0] crc;
    int          count;
    if (!v2) begin
      msg_id[23:8] = 16'h0000;
    end
    body.push_back(8'(len));
    if (v2) begin
      body.push_back(signed_frame ? 8'h01 : 8'h00);
      body.push_back(8'($urandom_range(0, 255)));
    end
    body.push_back(8'($urandom_range(0, 255)));
    body.push_back(sys);
    body.push_back(comp);
    body.push_back(msg_id[7:0]);
    if (v2) begin
      body.push_back(msg_id[15:8]);
      body.push_back(msg_id[23:16]);
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < stx_pct) begin
        body.push_back($urandom_range(0, 1) ? mfp_pkg::STX_ONE : mfp_pkg::STX_TWO);
      end else begin
        body.push_back(8'($urandom_range(0, 255)));
      end
    end
    crc = mfp_pkg::CRC_INIT;
    foreach (body[i]) begin
      crc = crc_mcrf(crc, body[i]);
    end
    crc = crc_mcrf(crc, extra_seed(msg_id));
    if (bad_crc) begin
      crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    end
    wire_bytes.push_back(v2 ? mfp_pkg::STX_TWO : mfp_pkg::STX_ONE);
    foreach (body[i]) begin
      wire_bytes.push_back(body[i]);
    end
    wire_bytes.push_back(crc[7:0]);
    wire_bytes.push_back(crc[15:8]);
    // Signature bytes avoid start codes so the next frame lines up.
    if (signed_frame) begin
      repeat (SIG_BYTES) wire_bytes.push_back(8'($urandom_range(0, 8'hFC)));
    end
    count = (keep > 0 && keep < wire_bytes.size()) ? keep : wire_bytes.size();
    for (int i = 0; i < count; i++) begin
      send_byte(wire_bytes[i]);
    end
  endtask

  // Fully random frame with mostly small payloads.
  task automatic send_random_frame(input int stx_pct, input int keep);
    bit v2;
    int roll;
    int len;
    v2   = $urandom_range(0, 1);
    roll = $urandom_range(0, 99);
    len  = (roll < 10) ? 0 : (roll < 95) ? $urandom_range(1, 16) : $urandom_range(17, 60);
    send_frame(v2, len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               pick_msg_id(), $urandom_range(0, 4) == 0, v2 && $urandom_range(0, 3) == 0,
               stx_pct, keep);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Noise at both byte extremes, an empty v1 frame with zero ids and a good CRC,
  // then a one-byte v2 frame with all-ones ids and a corrupted CRC.
  task automatic test_directed();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(1'b0, 0, 8'h00, 8'h00, 24'h000000, 1'b0, 1'b0, 0, 0);
    send_frame(1'b1, 1, 8'hFF, 8'hFF, 24'hFFFFFF, 1'b1, 1'b0, 0, 0);
  endtask

  // Well-formed random frames, the bulk of the traffic.
  task automatic test_random_frames();
    int target;
    target = bytes_sent + 320;
    while (bytes_sent < target) begin
      send_random_frame(2, 0);
    end
  endtask

  // Start bytes inside a frame must be taken as ordinary data.
  task automatic test_stx_in_frame();
    int target;
    target = bytes_sent + 150;
    send_frame(1'b1, 4, mfp_pkg::STX_TWO, mfp_pkg::STX_ONE, 24'd253, 1'b0, 1'b0, 50, 0);
    while (bytes_sent < target) begin
      send_random_frame(40, 0);
    end
  endtask

  // Signed v2 frames: the trailing signature is scanned as idle bytes.
  task automatic test_signed_frames();
    repeat (8) begin
      send_frame(1'b1, $urandom_range(0, 12), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), pick_msg_id(), $urandom_range(0, 3) == 0,
                 1'b1, 2, 0);
    end
  endtask

  // Truncated frames mixed with line noise; no resync inside a frame.
  task automatic test_broken_stream();
    int target;
    target = bytes_sent + 250;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 1)) begin
        send_random_frame(2, $urandom_range(1, 12));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // No idling on either side: full-rate throughput.
  task automatic test_back_to_back();
    int target;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    target    = bytes_sent + 150;
    while (bytes_sent < target) begin
      send_random_frame(2, 0);
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Longest payload in both versions; reaches payload index 254.
  task automatic test_long_payload();
    send_frame(1'b0, 255, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               pick_msg_id(), 1'b0, 1'b0, 2, 0);
    send_frame(1'b1, 255, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               pick_msg_id(), 1'b0, 1'b0, 2, 0);
  endtask

  initial begin
    // Hold every input at a known value from time zero.
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_rx_byte  = 8'h00;
    out_stall   = 1'b0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    stall_left  = 0;
    error_count = 0;
    cycle_count = 0;
    bytes_sent  = 0;

    phase        = HUNT;
    v2_frame     = 1'b0;
    frame_crc    = mfp_pkg::CRC_INIT;
    frame_len    = 8'h00;
    frame_sys    = 8'h00;
    frame_comp   = 8'h00;
    frame_msg_id = 24'h000000;
    payload_pos  = 8'h00;
    crc_lo_rx    = 8'h00;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_frames();
    test_stx_in_frame();
    test_signed_frames();
    test_broken_stream();
    test_back_to_back();
    test_long_payload();

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: wait for every owed result, then give stragglers time to show up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
